/* design/i2crm_pkg.sv */
// ----------------------------------------------------------------------------
// i2crm_pkg
// Types and constants shared by the I2C register access master core.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // Command codes carried by an input request.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] REG_TICKS_US  = 2'd1;
  localparam logic [1:0] REG_ACK_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] DEV_ADDR_RST  = 8'd0;
  localparam logic [7:0] TICKS_US_RST  = 8'd1;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

  // Bus sequencer phases.
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ST_A      = 4'd1;
  localparam logic [3:0] PH_ST_B      = 4'd2;
  localparam logic [3:0] PH_TX_LOW    = 4'd3;
  localparam logic [3:0] PH_TX_HIGH   = 4'd4;
  localparam logic [3:0] PH_TX_TAIL   = 4'd5;
  localparam logic [3:0] PH_ACK_SETUP = 4'd6;
  localparam logic [3:0] PH_ACK_HIGH  = 4'd7;
  localparam logic [3:0] PH_ACK_POLL  = 4'd8;
  localparam logic [3:0] PH_RX_LOW    = 4'd9;
  localparam logic [3:0] PH_RX_HIGH   = 4'd10;
  localparam logic [3:0] PH_NACK_LOW  = 4'd11;
  localparam logic [3:0] PH_NACK_HIGH = 4'd12;
  localparam logic [3:0] PH_SP_A      = 4'd13;
  localparam logic [3:0] PH_SP_B      = 4'd14;

  // Which byte of the access is being acknowledged.
  localparam logic [1:0] STG_ADDR = 2'd0;
  localparam logic [1:0] STG_REG  = 2'd1;
  localparam logic [1:0] STG_DATA = 2'd2;

  // Phase lengths in delay units, as a left shift of the tick rate.
  localparam logic [1:0] SH_UNIT1 = 2'd0;
  localparam logic [1:0] SH_UNIT2 = 2'd1;
  localparam logic [1:0] SH_UNIT4 = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] ticks_us;
    logic [7:0] ack_limit;
  } i2crm_cfg_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] bit_cnt;
    logic [7:0] shift_byte;
    logic [9:0] delay_cnt;
    logic [7:0] timeout_cnt;
    logic       is_read;
    logic [7:0] saved_reg;
    logic [7:0] saved_data;
    logic [7:0] rx_byte;
    logic       err;
    logic [1:0] stage;
  } i2crm_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_level;
  } i2crm_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } i2crm_result_t;

endpackage

/* design/i2crm_if.sv */
// ----------------------------------------------------------------------------
// i2crm_if
// Valid/ready channels of the I2C register access master core.
// ----------------------------------------------------------------------------

// Tick channel: one request per bus tick.
interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic       sda_level;

  modport source (output valid, command, register_address, write_data, sda_level,
                  input ready);
  modport sink   (input valid, command, register_address, write_data, sda_level,
                  output ready);
endinterface

// Result channel: one request per accepted tick.
interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_error;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, ack_error, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, ack_error, output ready);
endinterface

// Configuration write channel.
interface i2crm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/i2crm_step.sv */
// ----------------------------------------------------------------------------
// i2crm_step
// Next-state and pin logic of the bus sequencer for one tick.
// ----------------------------------------------------------------------------
module i2crm_step import i2crm_pkg::*; (
  input  i2crm_cfg_t    cfg_i,
  input  i2crm_state_t  cur_i,
  input  i2crm_item_t   item_i,
  output i2crm_state_t  nxt_o,
  output i2crm_result_t res_o
);

  logic       tx_bit;
  logic       scl;
  logic       pull;
  logic       done;
  logic [1:0] shamt;
  logic [9:0] limit;
  logic [9:0] dly_inc;
  logic       tm_done;
  logic [3:0] bit_inc;

  // Pin levels depend on the phase before this tick's update.
  always_comb begin
    tx_bit = ~cur_i.shift_byte[7];
    scl    = 1'b1;
    pull   = 1'b0;
    shamt  = SH_UNIT1;
    unique case (cur_i.phase)
      PH_ST_A: begin
        shamt = SH_UNIT4;
      end
      PH_ST_B: begin
        pull  = 1'b1;
        shamt = SH_UNIT4;
      end
      PH_TX_LOW, PH_TX_TAIL: begin
        scl   = 1'b0;
        pull  = tx_bit;
        shamt = SH_UNIT2;
      end
      PH_TX_HIGH: begin
        pull  = tx_bit;
        shamt = SH_UNIT2;
      end
      PH_ACK_SETUP: begin
        scl = 1'b0;
      end
      PH_RX_LOW, PH_NACK_LOW: begin
        scl   = 1'b0;
        shamt = SH_UNIT2;
      end
      PH_NACK_HIGH: begin
        shamt = SH_UNIT2;
      end
      PH_SP_A: begin
        scl   = 1'b0;
        pull  = 1'b1;
        shamt = SH_UNIT4;
      end
      PH_SP_B: begin
        shamt = SH_UNIT4;
      end
      default: begin
      end
    endcase
  end

  // Shared phase timer: the limit is the unit count times the tick rate.
  assign limit   = {2'b00, cfg_i.ticks_us} << shamt;
  assign dly_inc = cur_i.delay_cnt + 10'd1;
  assign tm_done = (dly_inc >= limit);
  assign bit_inc = cur_i.bit_cnt + 4'd1;

  always_comb begin
    nxt_o = cur_i;
    done  = 1'b0;
    unique case (cur_i.phase)
      PH_IDLE: begin
        if (item_i.command == CMD_WRITE || item_i.command == CMD_READ) begin
          nxt_o.is_read    = (item_i.command == CMD_READ);
          nxt_o.saved_reg  = item_i.register_address;
          nxt_o.saved_data = item_i.write_data;
          nxt_o.err        = 1'b0;
          nxt_o.stage      = STG_ADDR;
          nxt_o.shift_byte = cfg_i.dev_addr;
          nxt_o.phase      = PH_ST_A;
          nxt_o.delay_cnt  = '0;
        end
      end
      PH_ST_A, PH_TX_LOW, PH_TX_HIGH, PH_ACK_SETUP, PH_RX_LOW, PH_NACK_LOW,
      PH_NACK_HIGH, PH_SP_A: begin
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          nxt_o.delay_cnt = '0;
          unique case (cur_i.phase)
            PH_ST_A:      nxt_o.phase = PH_ST_B;
            PH_TX_LOW:    nxt_o.phase = PH_TX_HIGH;
            PH_TX_HIGH:   nxt_o.phase = PH_TX_TAIL;
            PH_ACK_SETUP: nxt_o.phase = PH_ACK_HIGH;
            PH_RX_LOW:    nxt_o.phase = PH_RX_HIGH;
            PH_NACK_LOW:  nxt_o.phase = PH_NACK_HIGH;
            PH_NACK_HIGH: nxt_o.phase = PH_SP_A;
            default:      nxt_o.phase = PH_SP_B;
          endcase
        end
      end
      PH_ST_B: begin
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          nxt_o.bit_cnt   = '0;
          nxt_o.phase     = PH_TX_LOW;
          nxt_o.delay_cnt = '0;
        end
      end
      PH_TX_TAIL: begin
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          nxt_o.shift_byte = {cur_i.shift_byte[6:0], 1'b0};
          nxt_o.bit_cnt    = bit_inc;
          nxt_o.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_SETUP : PH_TX_LOW;
          nxt_o.delay_cnt  = '0;
        end
      end
      PH_ACK_HIGH: begin
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          nxt_o.timeout_cnt = '0;
          nxt_o.phase       = PH_ACK_POLL;
          nxt_o.delay_cnt   = '0;
        end
      end
      PH_ACK_POLL: begin
        if (!item_i.sda_level) begin
          nxt_o.delay_cnt = '0;
          priority if (cur_i.stage == STG_ADDR) begin
            nxt_o.stage      = STG_REG;
            nxt_o.shift_byte = cur_i.saved_reg;
            nxt_o.bit_cnt    = '0;
            nxt_o.phase      = PH_TX_LOW;
          end else if (cur_i.stage == STG_REG) begin
            nxt_o.stage = STG_DATA;
            if (cur_i.is_read) begin
              // Repeated start with the read form of the address.
              nxt_o.shift_byte = cfg_i.dev_addr + 8'd1;
              nxt_o.phase      = PH_ST_A;
            end else begin
              nxt_o.shift_byte = cur_i.saved_data;
              nxt_o.bit_cnt    = '0;
              nxt_o.phase      = PH_TX_LOW;
            end
          end else if (cur_i.is_read) begin
            nxt_o.shift_byte = '0;
            nxt_o.bit_cnt    = '0;
            nxt_o.phase      = PH_RX_LOW;
          end else begin
            nxt_o.phase = PH_SP_A;
          end
        end else if (cur_i.timeout_cnt >= cfg_i.ack_limit) begin
          nxt_o.err       = 1'b1;
          nxt_o.phase     = PH_SP_A;
          nxt_o.delay_cnt = '0;
        end else begin
          nxt_o.timeout_cnt = cur_i.timeout_cnt + 8'd1;
        end
      end
      PH_RX_HIGH: begin
        if (cur_i.delay_cnt == '0) begin
          nxt_o.shift_byte = {cur_i.shift_byte[6:0], item_i.sda_level};
        end
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          nxt_o.bit_cnt   = bit_inc;
          nxt_o.phase     = (bit_inc >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RX_LOW;
          nxt_o.delay_cnt = '0;
        end
      end
      PH_SP_B: begin
        nxt_o.delay_cnt = dly_inc;
        if (tm_done) begin
          if (cur_i.is_read && !cur_i.err) begin
            nxt_o.rx_byte = cur_i.shift_byte;
          end
          done            = 1'b1;
          nxt_o.phase     = PH_IDLE;
          nxt_o.delay_cnt = '0;
        end
      end
      default: begin
        nxt_o.phase     = PH_IDLE;
        nxt_o.delay_cnt = '0;
      end
    endcase
  end

  always_comb begin
    res_o.scl_level    = scl;
    res_o.sda_pull_low = pull;
    res_o.busy_res     = (nxt_o.phase != PH_IDLE);
    res_o.done_res     = done;
    res_o.read_byte    = nxt_o.rx_byte;
    res_o.ack_error    = nxt_o.err;
  end

endmodule

/* design/i2c_register_access_master_core.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master_core
// Tick-driven I2C master performing one single-byte register read or write.
// ----------------------------------------------------------------------------
// Each request on the tick channel is one bus tick and carries a command, a
// register number, write data and the sampled SDA level. Every accepted tick
// produces exactly one result request, held in an output register, giving the
// SCL level and SDA pull-down for that tick together with busy, done, the last
// byte read and the acknowledge error flag. A tick is accepted in every cycle
// while the output register is empty or being taken, so the sustained rate is
// one tick per clock and a result appears in the cycle after its tick. Bus
// phases last a multiple of ticks_per_microsecond ticks; a missing
// acknowledge aborts the access through a stop sequence and sets the error
// flag. Configuration writes are always accepted and take effect at once.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core import i2crm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2crm_cfg_if.sink   cfg_i,
  i2crm_in_if.sink    in_i,
  i2crm_out_if.source out_o
);

  i2crm_cfg_t    cfg_q;
  i2crm_state_t  state_q;
  i2crm_state_t  state_d;
  i2crm_item_t   item;
  i2crm_result_t res_d;
  i2crm_result_t res_q;
  logic          out_valid_q;
  logic          in_ready;
  logic          in_fire;
  logic          cfg_fire;

  // The output register frees up in the same cycle its request is taken, so
  // a new tick can enter while the previous result is leaving.
  assign in_ready    = !out_valid_q || out_o.ready;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign item.command          = in_i.command;
  assign item.register_address = in_i.register_address;
  assign item.write_data       = in_i.write_data;
  assign item.sda_level        = in_i.sda_level;

  // Configuration registers. An index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr  <= DEV_ADDR_RST;
      cfg_q.ticks_us  <= TICKS_US_RST;
      cfg_q.ack_limit <= ACK_LIMIT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_DEV_ADDR:  cfg_q.dev_addr  <= cfg_i.data;
        REG_TICKS_US:  cfg_q.ticks_us  <= cfg_i.data;
        REG_ACK_LIMIT: cfg_q.ack_limit <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // The whole per-tick update of the sequencer.
  i2crm_step u_step (
    .cfg_i  (cfg_q),
    .cur_i  (state_q),
    .item_i (item),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // Sequencer state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scl_level    = res_q.scl_level;
  assign out_o.sda_pull_low = res_q.sda_pull_low;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.read_byte    = res_q.read_byte;
  assign out_o.ack_error    = res_q.ack_error;

  // A finished access is never reported as still busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done reported while busy");

  // A stalled result must block the tick channel.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("tick accepted while result stalled");

  // The phase timer is always cleared on the way back to idle.
  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> state_q.delay_cnt == '0)
    else $error("phase timer running in idle");

  // The acknowledge stage never goes past the data byte.
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q.stage != 2'd3)
    else $error("acknowledge stage out of range");

endmodule
